// ===== src/ssm_pkg.sv =====
// Shared constants, types and fp32 arithmetic for the diagonal SSM scan block.
`default_nettype none

package ssm_pkg;

    // Geometry
    localparam int CHANNELS = 64;
    localparam int PAIRS    = 32;
    localparam int DEPTH    = CHANNELS * PAIRS;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int N_W      = (PAIRS > 1) ? $clog2(PAIRS) : 1;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Item modes
    localparam logic [1:0] MODE_COEF   = 2'd0;
    localparam logic [1:0] MODE_GAIN   = 2'd1;
    localparam logic [1:0] MODE_SAMPLE = 2'd2;

    // fp32 codes
    localparam logic [31:0] FP_QUIET_BIT   = 32'h0040_0000;
    localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC0_0000;

    // Coefficients of one state slot
    typedef struct packed {
        logic [31:0] pole_re;
        logic [31:0] pole_im;
        logic [31:0] weight_re;
        logic [31:0] weight_im;
    } coef_t;

    // One complex state
    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
    } cstate_t;

    // Slot issued into the update pipeline
    typedef struct packed {
        logic           valid;
        logic           last;
        logic [N_W-1:0] idx;
    } issue_t;

    // State write-back from the pipeline
    typedef struct packed {
        logic           en;
        logic [N_W-1:0] idx;
        cstate_t        data;
    } wback_t;

    // Output term of one slot
    typedef struct packed {
        logic        valid;
        logic        last;
        logic [31:0] value;
    } term_t;

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] c;
        c = 6'd48;
        for (int i = 0; i < 48; i++)
        begin
            if (v[i])
            begin
                c = 6'(47 - i);
            end
        end
        return c;
    endfunction

    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] c;
        c = 5'd27;
        for (int i = 0; i < 27; i++)
        begin
            if (v[i])
            begin
                c = 5'(26 - i);
            end
        end
        return c;
    endfunction

    function automatic logic fp_is_nan(input logic [31:0] a);
        return (&a[30:23]) && (|a[22:0]);
    endfunction

    // fp32 multiply, round to nearest even, subnormals kept
    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic               s;
        logic               a_inf, b_inf, a_zero, b_zero;
        logic [7:0]         ea, eb;
        logic [23:0]        ma, mb;
        logic [47:0]        prod, pn;
        logic [5:0]         lz;
        logic signed [10:0] ex;
        logic [7:0]         shamt;
        logic               stk, rup;
        logic [23:0]        m24;
        logic [30:0]        mag;
        s      = a[31] ^ b[31];
        a_inf  = (a[30:0] == 31'h7F80_0000);
        b_inf  = (b[30:0] == 31'h7F80_0000);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        if (fp_is_nan(a))
        begin
            return a | FP_QUIET_BIT;
        end
        if (fp_is_nan(b))
        begin
            return b | FP_QUIET_BIT;
        end
        if ((a_inf && b_zero) || (b_inf && a_zero))
        begin
            return FP_DEFAULT_NAN;
        end
        if (a_inf || b_inf)
        begin
            return {s, 8'hFF, 23'd0};
        end
        if (a_zero || b_zero)
        begin
            return {s, 31'd0};
        end
        ea   = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb   = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma   = {|a[30:23], a[22:0]};
        mb   = {|b[30:23], b[22:0]};
        prod = ma * mb;
        lz   = lzc48(prod);
        pn   = prod << lz;
        ex   = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd126
             - $signed({5'b00000, lz});
        if (ex >= 11'sd255)
        begin
            return {s, 8'hFF, 23'd0};
        end
        stk = 1'b0;
        // Denormalize an underflowing result
        if (ex <= 11'sd0)
        begin
            shamt = 8'(11'sd1 - ex);
            stk   = |(pn & ((48'd1 << shamt) - 48'd1));
            pn    = pn >> shamt;
            ex    = 11'sd0;
        end
        m24 = pn[47:24];
        stk = stk | (|pn[22:0]);
        rup = pn[23] & (stk | m24[0]);
        mag = {ex[7:0], m24[22:0]} + 31'(rup);
        return {s, mag};
    endfunction

    // fp32 add (or subtract when sub is set), round to nearest even
    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b,
                                           input logic sub);
        logic [31:0] bb, l, sm;
        logic        a_inf, b_inf;
        logic [7:0]  el, es, d;
        logic [23:0] ml, ms;
        logic [26:0] lw, sw, sfull, r;
        logic [27:0] sum;
        logic [8:0]  e;
        logic [4:0]  lz;
        logic [8:0]  sh;
        logic [7:0]  ef;
        logic        rup;
        logic [30:0] mag;
        if (fp_is_nan(a))
        begin
            return a | FP_QUIET_BIT;
        end
        if (fp_is_nan(b))
        begin
            return b | FP_QUIET_BIT;
        end
        bb    = {b[31] ^ sub, b[30:0]};
        a_inf = (a[30:0] == 31'h7F80_0000);
        b_inf = (bb[30:0] == 31'h7F80_0000);
        if (a_inf && b_inf)
        begin
            return (a[31] == bb[31]) ? a : FP_DEFAULT_NAN;
        end
        if (a_inf)
        begin
            return a;
        end
        if (b_inf)
        begin
            return bb;
        end
        if ((a[30:0] == 31'd0) && (bb[30:0] == 31'd0))
        begin
            return {a[31] & bb[31], 31'd0};
        end
        // Order by magnitude
        if (a[30:0] >= bb[30:0])
        begin
            l  = a;
            sm = bb;
        end
        else
        begin
            l  = bb;
            sm = a;
        end
        el    = (l[30:23] == 8'd0) ? 8'd1 : l[30:23];
        es    = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
        ml    = {|l[30:23], l[22:0]};
        ms    = {|sm[30:23], sm[22:0]};
        d     = el - es;
        lw    = {ml, 3'b000};
        sfull = {ms, 3'b000};
        sw    = (sfull >> d) | 27'(|(sfull & ((27'd1 << d) - 27'd1)));
        if (l[31] == sm[31])
        begin
            sum = {1'b0, lw} + {1'b0, sw};
        end
        else
        begin
            sum = {1'b0, lw} - {1'b0, sw};
        end
        if (sum == 28'd0)
        begin
            return 32'd0;
        end
        e = {1'b0, el};
        // Normalize
        if (sum[27])
        begin
            r = {sum[27:2], sum[1] | sum[0]};
            e = e + 9'd1;
            if (e >= 9'd255)
            begin
                return {l[31], 8'hFF, 23'd0};
            end
        end
        else
        begin
            r  = sum[26:0];
            lz = lzc27(r);
            sh = ({4'd0, lz} < (e - 9'd1)) ? {4'd0, lz} : (e - 9'd1);
            r  = r << sh;
            e  = e - sh;
        end
        ef  = r[26] ? e[7:0] : 8'd0;
        rup = r[2] & (r[1] | r[0] | r[3]);
        mag = {ef, r[25:3]} + 31'(rup);
        return {l[31], mag};
    endfunction

endpackage

`default_nettype wire

// ===== src/ssm_lane.sv =====
// State update pipeline: complex pole times state plus sample, then weighted term.
`default_nettype none

module ssm_lane (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ssm_pkg::issue_t  iss,
    input  wire ssm_pkg::coef_t   coef,
    input  wire ssm_pkg::cstate_t st_rd,
    input  wire logic             zero_state,
    input  wire logic [31:0]      u,
    output ssm_pkg::wback_t       st_wr,
    output ssm_pkg::term_t        term
);
    import ssm_pkg::*;

    logic           v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic           l1_reg, l2_reg, l3_reg, l4_reg, l5_reg;
    logic [N_W-1:0] idx1_reg, idx2_reg, idx3_reg;
    logic [31:0]    p1_reg, p2_reg, p3_reg, p4_reg;
    logic [31:0]    wr1_reg, wi1_reg, wr2_reg, wi2_reg, wr3_reg, wi3_reg;
    logic [31:0]    dr2_reg, di2_reg, nr3_reg, di3_reg;
    logic [31:0]    q1_reg, q2_reg, term_reg;
    logic [31:0]    xr, xi;

    // Cleared or untouched channel reads as zero state
    assign xr = zero_state ? 32'd0 : st_rd.re;
    assign xi = zero_state ? 32'd0 : st_rd.im;

    // Advance stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= iss.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Arithmetic stages, one fp operation deep each
    always_ff @(posedge clk)
    begin
        // products of pole and state
        l1_reg   <= iss.last;
        idx1_reg <= iss.idx;
        p1_reg   <= fp_mul(coef.pole_re, xr);
        p2_reg   <= fp_mul(coef.pole_im, xi);
        p3_reg   <= fp_mul(coef.pole_re, xi);
        p4_reg   <= fp_mul(coef.pole_im, xr);
        wr1_reg  <= coef.weight_re;
        wi1_reg  <= coef.weight_im;
        // complex product sums
        l2_reg   <= l1_reg;
        idx2_reg <= idx1_reg;
        dr2_reg  <= fp_add(p1_reg, p2_reg, 1'b1);
        di2_reg  <= fp_add(p3_reg, p4_reg, 1'b0);
        wr2_reg  <= wr1_reg;
        wi2_reg  <= wi1_reg;
        // add the sample
        l3_reg   <= l2_reg;
        idx3_reg <= idx2_reg;
        nr3_reg  <= fp_add(dr2_reg, u, 1'b0);
        di3_reg  <= di2_reg;
        wr3_reg  <= wr2_reg;
        wi3_reg  <= wi2_reg;
        // weight the new state
        l4_reg   <= l3_reg;
        q1_reg   <= fp_mul(wr3_reg, nr3_reg);
        q2_reg   <= fp_mul(wi3_reg, di3_reg);
        // real part of the weighted state
        l5_reg   <= l4_reg;
        term_reg <= fp_add(q1_reg, q2_reg, 1'b1);
    end

    assign st_wr.en      = v3_reg;
    assign st_wr.idx     = idx3_reg;
    assign st_wr.data.re = nr3_reg;
    assign st_wr.data.im = di3_reg;

    assign term.valid = v5_reg;
    assign term.last  = l5_reg;
    assign term.value = term_reg;

endmodule

`default_nettype wire

// ===== src/diagonal_ssm_scan_core.sv =====
// Top level of the diagonal state-space scan: memories, sequencer and accumulator.
//
// Usage: one input channel (in_valid/in_ready) carries load and sample items,
// one output channel (out_valid/out_ready) carries one result per sample item.
// Mode 0 writes the pole and output weight of one (channel, state) slot, mode 1
// a channel's skip gain; both give no result. Mode 2 runs the channel's states
// through the update pipeline, one state read from the state memory per cycle,
// and returns skip_gain*sample plus the weighted state sum. A sample item
// occupies the block through its memory reads, the update pipeline and the
// final accumulation. Input is refused while a sample is in progress.
// After reset every channel's states read as zero (one valid bit per channel);
// coefficient and gain memories hold nothing until written. No clearing pass.
// A result waits in the output register while the receiver stalls; the block
// keeps taking items and finishes the next sample up to its result, then holds
// until the output register is free.
`default_nettype none

module diagonal_ssm_scan_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  mode,
    input  wire logic [5:0]  channel,
    input  wire logic [4:0]  state_index,
    input  wire logic [31:0] pole_re,
    input  wire logic [31:0] pole_im,
    input  wire logic [31:0] weight_re,
    input  wire logic [31:0] weight_im,
    input  wire logic [31:0] skip_gain,
    input  wire logic [31:0] sample,
    input  wire logic        sequence_start,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [5:0]       out_channel,
    output logic [31:0]      out_value
);
    import ssm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } fsm_t;

    fsm_t              state_reg, state_next;
    logic [N_W-1:0]    n_reg, n_next;
    logic [ADDR_W-1:0] base_reg;
    logic [5:0]        ch_reg;
    logic [31:0]       u_reg, y_reg, gain_rd_reg;
    logic              zero_reg;
    logic              out_valid_reg, out_valid_next;
    logic [5:0]        out_channel_reg;
    logic [31:0]       out_value_reg;
    logic [CHANNELS-1:0] chan_valid_reg;
    issue_t            iss_reg, iss_next;
    coef_t             coef_rd_reg;
    cstate_t           st_rd_reg;
    wback_t            st_wr;
    term_t             term;

    coef_t             coef_mem [DEPTH];
    cstate_t           st_mem   [DEPTH];
    logic [31:0]       gain_mem [CHANNELS];

    logic              in_acc, ch_ok, do_coef, do_gain, do_sample;
    logic              scan_last, out_free;
    logic [ADDR_W-1:0] load_addr, scan_addr;

    // Decode the item
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign ch_ok     = (32'(channel) < CHANNELS);
    assign do_coef   = in_acc && ch_ok && (mode == MODE_COEF) && (32'(state_index) < PAIRS);
    assign do_gain   = in_acc && ch_ok && (mode == MODE_GAIN);
    assign do_sample = in_acc && ch_ok && (mode == MODE_SAMPLE);
    assign load_addr = ADDR_W'(32'(channel) * PAIRS + 32'(state_index));
    assign scan_addr = base_reg + ADDR_W'(n_reg);
    assign scan_last = (n_reg == N_W'(PAIRS - 1));
    assign out_free  = !out_valid_reg || out_ready;

    // Sequence the scan
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        iss_next       = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                n_next = '0;
                if (do_sample)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                iss_next.valid = 1'b1;
                iss_next.last  = scan_last;
                iss_next.idx   = n_reg;
                n_next         = n_reg + N_W'(1);
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (term.valid && term.last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            n_reg          <= '0;
            iss_reg        <= '0;
            out_valid_reg  <= 1'b0;
            chan_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            iss_reg       <= iss_next;
            out_valid_reg <= out_valid_next;
            if (do_sample)
            begin
                chan_valid_reg[CH_W'(channel)] <= 1'b1;
            end
        end
    end

    // Latch sample context, accumulate the output
    always_ff @(posedge clk)
    begin
        if (do_sample)
        begin
            ch_reg   <= channel;
            base_reg <= ADDR_W'(32'(channel) * PAIRS);
            u_reg    <= sample;
            zero_reg <= sequence_start || !chan_valid_reg[CH_W'(channel)];
        end
        if ((state_reg == ST_SCAN) && (n_reg == '0))
        begin
            y_reg <= fp_mul(gain_rd_reg, u_reg);
        end
        else if (term.valid)
        begin
            y_reg <= fp_add(y_reg, term.value, 1'b0);
        end
        if ((state_reg == ST_FINISH) && out_free)
        begin
            out_channel_reg <= ch_reg;
            out_value_reg   <= y_reg;
        end
    end

    // Coefficient and gain memories
    always_ff @(posedge clk)
    begin
        if (do_coef)
        begin
            coef_mem[load_addr] <= '{pole_re, pole_im, weight_re, weight_im};
        end
        coef_rd_reg <= coef_mem[scan_addr];
    end

    always_ff @(posedge clk)
    begin
        if (do_gain)
        begin
            gain_mem[CH_W'(channel)] <= skip_gain;
        end
        gain_rd_reg <= gain_mem[CH_W'(channel)];
    end

    // State memory: read ahead, write back from the pipeline
    always_ff @(posedge clk)
    begin
        if (st_wr.en)
        begin
            st_mem[base_reg + ADDR_W'(st_wr.idx)] <= st_wr.data;
        end
        st_rd_reg <= st_mem[scan_addr];
    end

    ssm_lane u_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .iss        (iss_reg),
        .coef       (coef_rd_reg),
        .st_rd      (st_rd_reg),
        .zero_state (zero_reg),
        .u          (u_reg),
        .st_wr      (st_wr),
        .term       (term)
    );

    assign out_valid   = out_valid_reg;
    assign out_channel = out_channel_reg;
    assign out_value   = out_value_reg;

    // Pipeline is empty whenever a new item may enter
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!iss_reg.valid && !term.valid && !st_wr.en))
        else $error("update pipeline busy while accepting items");

    // Terms arrive only during a sample
    a_term_window: assert property (@(posedge clk) disable iff (!rst_n)
        term.valid |-> (state_reg == ST_SCAN || state_reg == ST_DRAIN))
        else $error("term outside a sample");

    // A finished sample lands in a free output register
    a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && !out_valid_reg) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("result not delivered to free output register");

endmodule

`default_nettype wire

// ===== tb/sv/diagonal_ssm_scan_core_tb.sv =====
// Testbench for the diagonal SSM scan core: directed and random items checked against an fp32 model.
`timescale 1ns / 100ps

module diagonal_ssm_scan_core_tb;
    import ssm_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         CYCLE_LIMIT = 600000;

    typedef struct {
        logic [5:0]  ch;
        logic [31:0] value;
    } scan_out_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  mode;
    logic [5:0]  channel;
    logic [4:0]  state_index;
    logic [31:0] pole_re;
    logic [31:0] pole_im;
    logic [31:0] weight_re;
    logic [31:0] weight_im;
    logic [31:0] skip_gain;
    logic [31:0] sample;
    logic        sequence_start;
    logic        out_valid;
    logic        out_ready;
    logic [5:0]  out_channel;
    logic [31:0] out_value;

    // scan model state
    logic [31:0] m_pole_re [DEPTH];
    logic [31:0] m_pole_im [DEPTH];
    logic [31:0] m_wgt_re  [DEPTH];
    logic [31:0] m_wgt_im  [DEPTH];
    logic [31:0] m_gain    [CHANNELS];
    logic [31:0] m_st_re   [DEPTH];
    logic [31:0] m_st_im   [DEPTH];
    bit          coef_set  [DEPTH];
    bit          gain_set  [CHANNELS];

    scan_out_t   pending_outs[$];
    int          live_ch[$];
    int          err_count;
    int          cycle_count;
    int          hold_cycles;
    bit          no_idle;

    diagonal_ssm_scan_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .channel        (channel),
        .state_index    (state_index),
        .pole_re        (pole_re),
        .pole_im        (pole_im),
        .weight_re      (weight_re),
        .weight_im      (weight_im),
        .skip_gain      (skip_gain),
        .sample         (sample),
        .sequence_start (sequence_start),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_channel    (out_channel),
        .out_value      (out_value)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Hard stop on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------- fp32 arithmetic through exact double ----------------

    function automatic real fp32_to_real(input logic [31:0] a);
        real r;
        if (a[30:23] == 8'hFF)
            return $bitstoreal({a[31], 11'h7FF, 52'd0});
        if (a[30:23] != 8'd0)
            return $bitstoreal({a[31], 11'(int'(a[30:23]) - 127 + 1023), a[22:0], 29'd0});
        r = real'(a[22:0]) * (2.0 ** (-149));
        if (a[31])
            r = -r;
        return r;
    endfunction

    // Round a double to fp32, nearest even, subnormals kept
    function automatic logic [31:0] real_to_fp32(input real r);
        logic [63:0] b;
        logic [63:0] sig;
        logic [63:0] kept;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] mag;
        int          e;
        int          sh;
        b = $realtobits(r);
        if (b[62:52] == 11'h7FF)
            return {b[63], 8'hFF, 23'd0};
        if (b[62:52] == 11'd0)
            return {b[63], 31'd0};
        e   = int'(b[62:52]) - 1023 + 127;
        sig = {11'd0, 1'b1, b[51:0]};
        sh  = (e >= 1) ? 29 : 29 + 1 - e;
        if (sh > 60)
            return {b[63], 31'd0};
        kept = sig >> sh;
        rem  = sig & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && kept[0]))
            kept = kept + 64'd1;
        mag = (((e >= 1) ? 64'(e - 1) : 64'd0) << 23) + kept;
        if (mag >= 64'h7F80_0000)
            return {b[63], 8'hFF, 23'd0};
        return {b[63], mag[30:0]};
    endfunction

    function automatic bit is_nan32(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    endfunction

    function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
        if (is_nan32(a))
            return a | FP_QUIET_BIT;
        if (is_nan32(b))
            return b | FP_QUIET_BIT;
        if ((a[30:0] == 31'h7F80_0000 && b[30:0] == 31'd0)
            || (b[30:0] == 31'h7F80_0000 && a[30:0] == 31'd0))
            return FP_DEFAULT_NAN;
        return real_to_fp32(fp32_to_real(a) * fp32_to_real(b));
    endfunction

    function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b,
                                            input bit neg_b);
        logic [31:0] bb;
        if (is_nan32(a))
            return a | FP_QUIET_BIT;
        if (is_nan32(b))
            return b | FP_QUIET_BIT;
        bb = {b[31] ^ neg_b, b[30:0]};
        if (a[30:0] == 31'h7F80_0000 && bb[30:0] == 31'h7F80_0000 && a[31] != bb[31])
            return FP_DEFAULT_NAN;
        return real_to_fp32(fp32_to_real(a) + fp32_to_real(bb));
    endfunction

    // ---------------- scan predictor ----------------

    task automatic scan_predict(input logic [1:0] md, input logic [5:0] ch,
                                input logic [4:0] idx, input logic [31:0] pr,
                                input logic [31:0] pi, input logic [31:0] wr,
                                input logic [31:0] wi, input logic [31:0] g,
                                input logic [31:0] u, input logic st);
        int          base;
        int          k;
        logic [31:0] y;
        logic [31:0] dr;
        logic [31:0] di;
        logic [31:0] nr;
        scan_out_t   res;
        base = int'(ch) * PAIRS;
        case (md)
            MODE_COEF:
            begin
                k = base + int'(idx);
                m_pole_re[k] = pr;
                m_pole_im[k] = pi;
                m_wgt_re[k]  = wr;
                m_wgt_im[k]  = wi;
                coef_set[k]  = 1'b1;
            end
            MODE_GAIN:
            begin
                m_gain[ch]   = g;
                gain_set[ch] = 1'b1;
            end
            MODE_SAMPLE:
            begin
                // clear on sequence start, then update each state in ascending order
                if (st)
                begin
                    for (int n = 0; n < PAIRS; n++)
                    begin
                        m_st_re[base + n] = 32'd0;
                        m_st_im[base + n] = 32'd0;
                    end
                end
                y = f32_mul(m_gain[ch], u);
                for (int n = 0; n < PAIRS; n++)
                begin
                    k  = base + n;
                    dr = f32_add(f32_mul(m_pole_re[k], m_st_re[k]),
                                 f32_mul(m_pole_im[k], m_st_im[k]), 1'b1);
                    di = f32_add(f32_mul(m_pole_re[k], m_st_im[k]),
                                 f32_mul(m_pole_im[k], m_st_re[k]), 1'b0);
                    nr = f32_add(dr, u, 1'b0);
                    m_st_re[k] = nr;
                    m_st_im[k] = di;
                    y = f32_add(y, f32_add(f32_mul(m_wgt_re[k], nr),
                                           f32_mul(m_wgt_im[k], di), 1'b1), 1'b0);
                end
                res.ch    = ch;
                res.value = y;
                pending_outs.push_back(res);
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic bit channel_loaded(input int ch);
        if (!gain_set[ch])
            return 1'b0;
        for (int n = 0; n < PAIRS; n++)
        begin
            if (!coef_set[ch * PAIRS + n])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // ---------------- random values ----------------

    function automatic logic [31:0] special_fp();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'h8000_0000;
            2: return 32'h7F80_0000;
            3: return 32'hFF80_0000;
            4: return 32'h7FC0_0001;
            5: return 32'hFF80_1234;
            6: return 32'h0000_0001;
            7: return 32'h8070_0000;
            8: return 32'h7F7F_FFFF;
            default: return 32'h3F80_0000;
        endcase
    endfunction

    // Moderate value with exponent in [lo, hi], sometimes raw bits or a special
    function automatic logic [31:0] rand_fp(input int lo, input int hi);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 4)
            return $urandom();
        if (sel < 7)
            return special_fp();
        return {1'($urandom()), 8'($urandom_range(lo, hi)), 23'($urandom())};
    endfunction

    function automatic int gap_len();
        int sel;
        if (no_idle)
            return 0;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return 0;
        if (sel < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ---------------- driving and checking ----------------

    task automatic send_item(input logic [1:0] md, input logic [5:0] ch,
                             input logic [4:0] idx, input logic [31:0] pr,
                             input logic [31:0] pi, input logic [31:0] wr,
                             input logic [31:0] wi, input logic [31:0] g,
                             input logic [31:0] u, input logic st);
        int gap;
        mode           <= md;
        channel        <= ch;
        state_index    <= idx;
        pole_re        <= pr;
        pole_im        <= pi;
        weight_re      <= wr;
        weight_im      <= wi;
        skip_gain      <= g;
        sample         <= u;
        sequence_start <= st;
        in_valid       <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        scan_predict(md, ch, idx, pr, pi, wr, wi, g, u, st);
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic load_coef(input int ch, input int idx);
        send_item(MODE_COEF, 6'(ch), 5'(idx), rand_fp(118, 126), rand_fp(110, 125),
                  rand_fp(118, 128), rand_fp(118, 128), $urandom(), $urandom(),
                  1'($urandom()));
    endtask

    task automatic load_gain(input int ch);
        send_item(MODE_GAIN, 6'(ch), 5'($urandom()), $urandom(), $urandom(), $urandom(),
                  $urandom(), rand_fp(120, 130), $urandom(), 1'($urandom()));
    endtask

    task automatic send_sample(input int ch, input logic [31:0] u, input logic st);
        send_item(MODE_SAMPLE, 6'(ch), 5'($urandom()), $urandom(), $urandom(), $urandom(),
                  $urandom(), $urandom(), u, st);
    endtask

    // Load every slot and the gain of one channel
    task automatic load_channel(input int ch);
        for (int n = 0; n < PAIRS; n++)
            load_coef(ch, n);
        load_gain(ch);
        live_ch.push_back(ch);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        $display("MISMATCH %s: got %h, expected %h (cycle %0d)", what, got, want, cycle_count);
    endtask

    // Check each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        scan_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_outs.size() == 0)
            begin
                report_mismatch("unexpected result", {26'd0, out_channel}, 32'd0);
            end
            else
            begin
                want = pending_outs.pop_front();
                if (out_channel !== want.ch)
                    report_mismatch("out_channel", {26'd0, out_channel}, {26'd0, want.ch});
                if (out_value !== want.value)
                    report_mismatch("out_value", out_value, want.value);
            end
        end
    end

    // Receiver: random stalls, long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_ready   <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end
            else if (stall_left > 0)
            begin
                out_ready  <= 1'b0;
                stall_left = stall_left - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                stall_left = gap_len();
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_setup_channels();
        load_channel(0);
        load_channel(CHANNELS - 1);
        for (int i = 0; i < 2; i++)
            load_channel(1 + 31 * i + $urandom_range(0, 30));
    endtask

    // Extremes of the sample and of the flags
    task automatic test_directed();
        send_sample(0, 32'h0000_0000, 1'b1);
        send_sample(0, 32'h3F80_0000, 1'b0);
        send_sample(0, 32'hBF80_0000, 1'b0);
        send_sample(CHANNELS - 1, 32'h7F7F_FFFF, 1'b1);
        send_sample(CHANNELS - 1, 32'hFF7F_FFFF, 1'b0);
        send_sample(0, 32'h0000_0001, 1'b1);
        send_sample(0, 32'h8000_0000, 1'b0);
        send_sample(0, 32'h7F80_0000, 1'b0);
        send_sample(0, 32'h3F00_0000, 1'b1);
        send_sample(0, 32'h7FA0_0001, 1'b0);
        send_sample(0, 32'h4000_0000, 1'b1);
        // unused mode changes nothing
        send_item(MODE_UNUSED, 6'd0, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_sample(0, 32'h4000_0000, 1'b0);
        // rewrite last slot with an extreme pole, then a gain of zero
        send_item(MODE_COEF, 6'(CHANNELS - 1), 5'(PAIRS - 1), 32'h3F7F_FFFF, 32'h8000_0000,
                  32'hFFFF_FFFF, 32'h0000_0000, 32'd0, 32'd0, 1'b0);
        send_item(MODE_GAIN, 6'(CHANNELS - 1), 5'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                  32'h0000_0000, 32'd0, 1'b0);
        send_sample(CHANNELS - 1, 32'h3FC0_0000, 1'b1);
        send_sample(CHANNELS - 1, 32'hC2C8_0000, 1'b0);
    endtask

    // Mostly sample streams on loaded channels, with loads and noise mixed in
    task automatic test_random(input int items);
        int sel;
        int ch;
        for (int i = 0; i < items; i++)
        begin
            no_idle = (i >= items / 2 && i < items / 2 + 40);
            sel = $urandom_range(0, 99);
            ch  = live_ch[$urandom_range(0, live_ch.size() - 1)];
            if (sel < 60)
                send_sample(ch, rand_fp(115, 131), ($urandom_range(0, 9) == 0));
            else if (sel < 78)
                load_coef($urandom_range(0, 1) ? ch : $urandom_range(0, CHANNELS - 1),
                          $urandom_range(0, PAIRS - 1));
            else if (sel < 86)
                load_gain($urandom_range(0, 1) ? ch : $urandom_range(0, CHANNELS - 1));
            else if (sel < 92)
                send_item(MODE_UNUSED, 6'($urandom()), 5'($urandom()), $urandom(),
                          $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                          1'($urandom()));
            else if (sel < 93)
            begin
                ch = $urandom_range(0, CHANNELS - 1);
                if (!channel_loaded(ch))
                    load_channel(ch);
            end
            else
                send_sample(ch, $urandom(), 1'($urandom()));
        end
        no_idle = 1'b0;
    endtask

    // Long receiver hold-off while samples keep coming
    task automatic test_output_backpressure();
        no_idle     = 1'b1;
        hold_cycles = 400;
        for (int i = 0; i < 8; i++)
            send_sample(live_ch[$urandom_range(0, live_ch.size() - 1)], rand_fp(120, 128),
                        1'b0);
        no_idle = 1'b0;
    endtask

    initial
    begin
        err_count   = 0;
        cycle_count = 0;
        hold_cycles = 0;
        no_idle     = 1'b0;
        for (int k = 0; k < DEPTH; k++)
        begin
            m_pole_re[k] = 32'd0;
            m_pole_im[k] = 32'd0;
            m_wgt_re[k]  = 32'd0;
            m_wgt_im[k]  = 32'd0;
            m_st_re[k]   = 32'd0;
            m_st_im[k]   = 32'd0;
            coef_set[k]  = 1'b0;
        end
        for (int c = 0; c < CHANNELS; c++)
        begin
            m_gain[c]   = 32'd0;
            gain_set[c] = 1'b0;
        end
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        mode           <= MODE_COEF;
        channel        <= 6'd0;
        state_index    <= 5'd0;
        pole_re        <= 32'd0;
        pole_im        <= 32'd0;
        weight_re      <= 32'd0;
        weight_im      <= 32'd0;
        skip_gain      <= 32'd0;
        sample         <= 32'd0;
        sequence_start <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_setup_channels();
        test_directed();
        test_random(100);
        test_output_backpressure();
        test_random(100);

        // drain, then allow for the block's latency
        in_valid <= 1'b0;
        while (pending_outs.size() != 0)
            @(posedge clk);
        repeat (2 * (PAIRS + 8)) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
